// ===== rtl/spsv_pkg.sv =====
// spsv_pkg: constants, control word types and microcode ROM for the
// stack pop sequence validator. No dependencies.
`default_nettype none

package spsv_pkg;

	localparam int DATA_W      = 6;
	localparam int MAX_LEN_DEF = 32;
	localparam int PC_W        = 3;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_PUSH,
		OP_CHECK,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_NO_INPUT,
		C_FAILED,
		C_CAN_PUSH,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ctrl_word_t;

	localparam logic [PC_W-1:0] STEP_ACCEPT = PC_W'(0);
	localparam logic [PC_W-1:0] STEP_GATE   = PC_W'(1);
	localparam logic [PC_W-1:0] STEP_PUSH   = PC_W'(2);
	localparam logic [PC_W-1:0] STEP_CHECK  = PC_W'(3);
	localparam logic [PC_W-1:0] STEP_EMIT   = PC_W'(7);

	// Untaken jump falls through to pc + 1; EMIT wraps back to ACCEPT.
	function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
		ctrl_word_t cw;
		unique case (pc)
			STEP_ACCEPT: cw = '{op: OP_ACCEPT, cond: C_NO_INPUT, target: STEP_ACCEPT};
			STEP_GATE:   cw = '{op: OP_NONE,   cond: C_FAILED,   target: STEP_EMIT};
			STEP_PUSH:   cw = '{op: OP_PUSH,   cond: C_CAN_PUSH, target: STEP_PUSH};
			STEP_CHECK:  cw = '{op: OP_CHECK,  cond: C_ALWAYS,   target: STEP_EMIT};
			STEP_EMIT:   cw = '{op: OP_EMIT,   cond: C_OUT_BUSY, target: STEP_EMIT};
			default:     cw = '{op: OP_NONE,   cond: C_ALWAYS,   target: STEP_ACCEPT};
		endcase
		return cw;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/stack_pop_sequence_validator.sv =====
// Stack pop sequence validator: checks a stream of numbers against the pop
// orders one stack can produce from ascending pushes 1, 2, 3, ...
// Input channel in_valid/in_ready carries car_number and last_item; output
// channel out_valid/out_ready carries still_valid and sequence_end, one
// result transaction per input transaction, in order.
// Control runs from a small microcode ROM (spsv_pkg) with a step counter
// and conditional jumps; the stack lives in a MAX_LEN entry memory with a
// registered read port, the top entry cached in a register.
// Steps: an item that pushes k numbers passes accept, gate, push loop,
// check and the result step into the output register (k up to MAX_LEN,
// one push per cycle on the memory write port); a failed sequence skips
// push loop and check. The next item is accepted the cycle after the result.
// A stalled receiver holds the result in the output register; the block
// still accepts and processes the next item and then waits at the result
// step until the register frees.
// Reset (arst_n low) empties the stack, sets the next push to 1, clears the
// verdict and drops out_valid; no clearing pass is needed. An item with
// last_item set clears stack depth, next push and failure flag on its result.
`default_nettype none

module stack_pop_sequence_validator
	import spsv_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [DATA_W-1:0] car_number,
	input  wire logic              last_item,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   still_valid,
	output logic                   sequence_end
);

	localparam int AW   = $clog2(MAX_LEN);
	localparam int DW_C = $clog2(MAX_LEN + 1);
	localparam int NW   = $clog2(MAX_LEN + 2);
	localparam int CMPW = (NW > DATA_W) ? NW : DATA_W;

	localparam logic [DW_C-1:0] DEPTH_MAX = DW_C'(MAX_LEN);
	localparam logic [NW-1:0]   NEXT_MAX  = NW'(MAX_LEN);
	localparam logic [NW-1:0]   NEXT_INIT = NW'(1);

	logic [PC_W-1:0]   pc_q;
	logic [DW_C-1:0]   depth_q;
	logic [NW-1:0]     next_q;
	logic              failed_q;
	logic [DATA_W-1:0] num_q;
	logic              last_q;
	logic [DATA_W-1:0] top_q;
	logic              out_valid_q;
	logic              still_valid_q;
	logic              seq_end_q;

	logic [DATA_W-1:0] mem [MAX_LEN];
	logic [DATA_W-1:0] rdata_q;

	ctrl_word_t        cw;
	logic              cond_true;
	logic              can_push;
	logic              mismatch;
	logic              out_busy;
	logic              do_push;
	logic              do_pop;
	logic              do_read;
	logic              do_emit;
	logic [DW_C-1:0]   rd_depth;

	assign cw = ucode_rom(pc_q);

	assign can_push = (CMPW'(next_q) <= CMPW'(num_q)) && (next_q <= NEXT_MAX)
			&& (depth_q < DEPTH_MAX) && !failed_q;
	assign mismatch = (depth_q == '0) || (top_q != num_q);
	assign out_busy = out_valid_q && !out_ready;

	assign do_push  = (cw.op == OP_PUSH) && can_push;
	assign do_pop   = (cw.op == OP_CHECK) && !mismatch;
	assign do_read  = do_pop && (depth_q >= DW_C'(2));
	assign do_emit  = (cw.op == OP_EMIT) && !out_busy;
	assign rd_depth = depth_q - DW_C'(2);

	always_comb begin
		unique case (cw.cond)
			C_ALWAYS:   cond_true = 1'b1;
			C_NO_INPUT: cond_true = !in_valid;
			C_FAILED:   cond_true = failed_q;
			C_CAN_PUSH: cond_true = can_push;
			C_OUT_BUSY: cond_true = out_busy;
			default:    cond_true = 1'b1;
		endcase
	end

	assign in_ready     = (cw.op == OP_ACCEPT);
	assign out_valid    = out_valid_q;
	assign still_valid  = still_valid_q;
	assign sequence_end = seq_end_q;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[depth_q[AW-1:0]] <= DATA_W'(next_q);
		end
		if (do_read) begin
			rdata_q <= mem[rd_depth[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q          <= STEP_ACCEPT;
			depth_q       <= '0;
			next_q        <= NEXT_INIT;
			failed_q      <= 1'b0;
			out_valid_q   <= 1'b0;
			num_q         <= '0;
			last_q        <= 1'b0;
			top_q         <= '0;
			still_valid_q <= 1'b0;
			seq_end_q     <= 1'b0;
		end else begin
			pc_q <= cond_true ? cw.target : pc_q + 1'b1;

			if (in_valid && in_ready) begin
				num_q  <= car_number;
				last_q <= last_item;
			end

			if (do_push) begin
				top_q   <= DATA_W'(next_q);
				depth_q <= depth_q + 1'b1;
				next_q  <= next_q + 1'b1;
			end

			if (cw.op == OP_CHECK) begin
				if (mismatch) begin
					failed_q <= 1'b1;
				end else begin
					depth_q <= depth_q - 1'b1;
				end
			end

			if (out_valid_q && out_ready && !do_emit) begin
				out_valid_q <= 1'b0;
			end

			if (do_emit) begin
				out_valid_q   <= 1'b1;
				still_valid_q <= !failed_q;
				seq_end_q     <= last_q;
				top_q         <= rdata_q;
				if (last_q) begin
					depth_q  <= '0;
					next_q   <= NEXT_INIT;
					failed_q <= 1'b0;
				end
			end
		end
	end

	a_accept_leaves_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("accepted a second transaction without processing the first");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_MAX)
		else $error("stack depth beyond capacity");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(do_emit && last_q) |=> (depth_q == '0) && (next_q == NEXT_INIT) && !failed_q)
		else $error("final result did not clear the sequence state");

	a_top_below_next: assert property (@(posedge clk) disable iff (!arst_n)
		((depth_q != '0) && !failed_q) |-> (CMPW'(top_q) < CMPW'(next_q)))
		else $error("cached stack top not below next push value");

endmodule

`default_nettype wire
